// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the code lock.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define KCL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define KCL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/kcl_pkg.sv =====
// Types, codes and reset constants of the keypad code lock.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int MaxDigitsDef = 9;
  localparam int SecretW      = 36;
  localparam int CfgDataW     = 36;
  localparam int CfgIdxW      = 3;

  localparam logic [35:0] SecretCodeRst = 36'h311197531;
  localparam logic [3:0]  CodeLengthRst = 4'd9;
  localparam logic [3:0]  MaxFailRst    = 4'd3;
  localparam logic [7:0]  LockSecRst    = 8'd60;
  localparam logic [7:0]  UnlockSecRst  = 8'd5;
  localparam logic [9:0]  ThresholdRst  = 10'd450;

  localparam logic [1:0] ModeKey  = 2'd0;
  localparam logic [1:0] ModeTick = 2'd1;

  localparam logic [3:0] KeyDigitMax = 4'd9;
  localparam logic [3:0] KeyStar     = 4'd10;
  localparam logic [3:0] KeyHash     = 4'd11;
  localparam logic [3:0] FailSat     = 4'd15;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ENTER = 2'd1,
    PH_OPEN  = 2'd2,
    PH_LOCK  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_START     = 3'd1,
    EV_DIGIT     = 3'd2,
    EV_ACCEPT    = 3'd3,
    EV_REJECT    = 3'd4,
    EV_LOCKOUT   = 3'd5,
    EV_INTRUSION = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    CFG_SECRET    = 3'd0,
    CFG_LENGTH    = 3'd1,
    CFG_MAX_FAIL  = 3'd2,
    CFG_LOCK_SEC  = 3'd3,
    CFG_OPEN_SEC  = 3'd4,
    CFG_THRESHOLD = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] key;
    logic [9:0] sensor_level;
  } kcl_in_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       alarm;
    logic       door_open;
    logic [3:0] digits_entered;
    logic [3:0] tries_left;
    logic [7:0] seconds_left;
    logic [2:0] event_res;
  } kcl_out_t;

  typedef struct packed {
    logic [35:0] secret_code;
    logic [3:0]  code_length;
    logic [3:0]  max_failures;
    logic [7:0]  lockout_seconds;
    logic [7:0]  unlock_seconds;
    logic [9:0]  intrusion_threshold;
  } kcl_cfg_t;

endpackage

// ===== hw/rtl/kcl_step.sv =====
// Lock state, entry buffer and the per-word update of the code lock.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_step #(
  parameter int MAX_DIGITS = kcl_pkg::MaxDigitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  kcl_pkg::kcl_in_t  word_i,
  input  kcl_pkg::kcl_cfg_t cfg_i,
  output kcl_pkg::kcl_out_t res_o
);

  localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int ExtW = (4 * MAX_DIGITS > kcl_pkg::SecretW) ?
                        4 * MAX_DIGITS : kcl_pkg::SecretW;

  kcl_pkg::phase_e phase_q, phase_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [3:0]      fail_q, fail_d;
  logic            alarm_q, alarm_d;
  logic [7:0]      cd_q, cd_d;
  logic [3:0]      buf_q [MAX_DIGITS];

  kcl_pkg::event_e      ev;
  logic                 dig_we;
  logic [4:0]           cap;
  logic [3:0]           fail_inc;
  logic [ExtW-1:0]      code_ext;
  logic [MAX_DIGITS-1:0] pos_ok;
  logic                 match;

  assign code_ext = ExtW'(cfg_i.secret_code);

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_pos
    assign pos_ok[i] = (4'(i) >= cnt_q) || (buf_q[i] == code_ext[4*i +: 4]);
  end

  assign match    = (cnt_q == cfg_i.code_length) && (&pos_ok);
  assign cap      = ({1'b0, cfg_i.code_length} < 5'(MAX_DIGITS)) ?
                    {1'b0, cfg_i.code_length} : 5'(MAX_DIGITS);
  assign fail_inc = (fail_q != kcl_pkg::FailSat) ? fail_q + 4'd1 : fail_q;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    fail_d  = fail_q;
    alarm_d = alarm_q;
    cd_d    = cd_q;
    ev      = kcl_pkg::EV_NONE;
    dig_we  = 1'b0;

    if (phase_q != kcl_pkg::PH_OPEN) begin
      if (word_i.sensor_level < cfg_i.intrusion_threshold) begin
        if (!alarm_q) begin
          alarm_d = 1'b1;
          ev      = kcl_pkg::EV_INTRUSION;
          cnt_d   = '0;
          if (phase_q == kcl_pkg::PH_ENTER) begin
            phase_d = kcl_pkg::PH_IDLE;
          end
        end
      end else begin
        alarm_d = 1'b0;
      end
    end

    if (word_i.mode == kcl_pkg::ModeTick) begin
      if (phase_d == kcl_pkg::PH_OPEN || phase_d == kcl_pkg::PH_LOCK) begin
        if (cd_q != '0) begin
          cd_d = cd_q - 8'd1;
        end
        if (cd_d == '0) begin
          if (phase_d == kcl_pkg::PH_LOCK) begin
            alarm_d = 1'b0;
            fail_d  = '0;
          end
          phase_d = kcl_pkg::PH_IDLE;
        end
      end
    end else if (word_i.mode == kcl_pkg::ModeKey && !alarm_d) begin
      priority if (phase_d == kcl_pkg::PH_IDLE && word_i.key == kcl_pkg::KeyStar) begin
        cnt_d   = '0;
        phase_d = kcl_pkg::PH_ENTER;
        ev      = kcl_pkg::EV_START;
      end else if (phase_d == kcl_pkg::PH_ENTER && word_i.key <= kcl_pkg::KeyDigitMax) begin
        if ({1'b0, cnt_q} < cap) begin
          dig_we = 1'b1;
          cnt_d  = cnt_q + 4'd1;
          ev     = kcl_pkg::EV_DIGIT;
        end
      end else if (phase_d == kcl_pkg::PH_ENTER && word_i.key == kcl_pkg::KeyHash) begin
        cnt_d = '0;
        if (match) begin
          phase_d = kcl_pkg::PH_OPEN;
          cd_d    = cfg_i.unlock_seconds;
          fail_d  = '0;
          ev      = kcl_pkg::EV_ACCEPT;
        end else begin
          fail_d = fail_inc;
          if (fail_inc >= cfg_i.max_failures) begin
            phase_d = kcl_pkg::PH_LOCK;
            cd_d    = cfg_i.lockout_seconds;
            ev      = kcl_pkg::EV_LOCKOUT;
          end else begin
            phase_d = kcl_pkg::PH_IDLE;
            ev      = kcl_pkg::EV_REJECT;
          end
        end
      end else begin
        ev = kcl_pkg::EV_NONE;
      end
    end
  end

  always_comb begin
    res_o.phase          = phase_d;
    res_o.alarm          = alarm_d;
    res_o.door_open      = (phase_d == kcl_pkg::PH_OPEN);
    res_o.digits_entered = cnt_d;
    res_o.tries_left     = (cfg_i.max_failures > fail_d) ? cfg_i.max_failures - fail_d : '0;
    res_o.seconds_left   = (phase_d == kcl_pkg::PH_OPEN || phase_d == kcl_pkg::PH_LOCK) ?
                           cd_d : '0;
    res_o.event_res      = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kcl_pkg::PH_IDLE;
      cnt_q   <= '0;
      fail_q  <= '0;
      alarm_q <= 1'b0;
      cd_q    <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fail_q  <= fail_d;
      alarm_q <= alarm_d;
      cd_q    <= cd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && dig_we) begin
      buf_q[cnt_q[IdxW-1:0]] <= word_i.key;
    end
  end

endmodule

// ===== hw/rtl/keypad_code_lock_with_lockout_unit.sv =====
// Top level of the keypad code lock: input register, configuration
// registers, output register. Depends on kcl_pkg and kcl_step.
//
//   port group    direction  handshake            payload
//   in_*          in         in_valid_i/in_stall_o  kcl_in_t
//   out_*         out        out_valid_o/out_stall_i kcl_out_t
//   cfg_*         in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Each word is captured in the input register, passes the state update
// in kcl_step and leaves in the output register; one word per cycle is
// sustained while the output does not stall. The kcl_step update sets the rate.
// Reset clears the lock state and loads the default code and timings.
// A stalled output holds its word; the input stalls only when both
// registers are full.
`timescale 1ns / 1ps

module keypad_code_lock_with_lockout_unit #(
  parameter int MAX_DIGITS = kcl_pkg::MaxDigitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  kcl_pkg::kcl_in_t             in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output kcl_pkg::kcl_out_t            out_word_o,
  input  logic                         cfg_we_i,
  input  logic [kcl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kcl_pkg::CfgDataW-1:0] cfg_wdata_i
);

  kcl_pkg::kcl_cfg_t cfg_q;
  kcl_pkg::kcl_in_t  in_q;
  logic              in_vld_q;
  kcl_pkg::kcl_out_t out_q;
  kcl_pkg::kcl_out_t res;
  logic              out_vld_q;
  logic              adv;
  logic              in_acc;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.secret_code         <= kcl_pkg::SecretCodeRst;
      cfg_q.code_length         <= kcl_pkg::CodeLengthRst;
      cfg_q.max_failures        <= kcl_pkg::MaxFailRst;
      cfg_q.lockout_seconds     <= kcl_pkg::LockSecRst;
      cfg_q.unlock_seconds      <= kcl_pkg::UnlockSecRst;
      cfg_q.intrusion_threshold <= kcl_pkg::ThresholdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kcl_pkg::CFG_SECRET:    cfg_q.secret_code         <= cfg_wdata_i[35:0];
        kcl_pkg::CFG_LENGTH:    cfg_q.code_length         <= cfg_wdata_i[3:0];
        kcl_pkg::CFG_MAX_FAIL:  cfg_q.max_failures        <= cfg_wdata_i[3:0];
        kcl_pkg::CFG_LOCK_SEC:  cfg_q.lockout_seconds     <= cfg_wdata_i[7:0];
        kcl_pkg::CFG_OPEN_SEC:  cfg_q.unlock_seconds      <= cfg_wdata_i[7:0];
        kcl_pkg::CFG_THRESHOLD: cfg_q.intrusion_threshold <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_word_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  kcl_step #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .word_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/kcl_chk.sv =====
// Port-level checker of the keypad code lock, bound to the top level.
// Depends on kcl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kcl_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input kcl_pkg::kcl_out_t out_word_o
);

  property p_out_hold;
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o);
  endproperty

  property p_in_stall_cause;
    in_stall_o |-> out_valid_o && out_stall_i;
  endproperty

  property p_no_alarm_open;
    out_valid_o |-> !(out_word_o.alarm && out_word_o.phase == kcl_pkg::PH_OPEN);
  endproperty

  property p_lockout_word;
    out_valid_o && out_word_o.event_res == kcl_pkg::EV_LOCKOUT |->
      out_word_o.phase == kcl_pkg::PH_LOCK && out_word_o.tries_left == 4'd0;
  endproperty

  // a lockout ending on the same tick may clear the alarm again
  property p_intrusion_word;
    out_valid_o && out_word_o.event_res == kcl_pkg::EV_INTRUSION |->
      out_word_o.digits_entered == 4'd0 && !out_word_o.door_open;
  endproperty

  `KCL_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled output word changed")
  `KCL_ASSERT(a_in_stall_cause, clk_i, rst_ni, p_in_stall_cause, "input stalled without cause")
  `KCL_ASSERT(a_no_alarm_open, clk_i, rst_ni, p_no_alarm_open, "alarm raised while unlocked")
  `KCL_ASSERT(a_lockout_word, clk_i, rst_ni, p_lockout_word, "lockout word inconsistent")
  `KCL_ASSERT(a_intrusion_word, clk_i, rst_ni, p_intrusion_word, "intrusion word inconsistent")

endmodule

bind keypad_code_lock_with_lockout_unit kcl_chk u_kcl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
